// ----- rtl/wtsp_pkg.sv -----
package wtsp_pkg;

    localparam int COORD_FRAC_BITS = 8;
    localparam int AXIS_FRAC_BITS  = 14;

    // datapath widths
    localparam int DW  = 33;            // point minus origin
    localparam int PW  = 49;            // offset times axis word
    localparam int SW  = 51;            // dot product
    localparam int MW  = 50;            // depth and coordinate magnitudes
    localparam int TW  = 24;            // tangent
    localparam int VW  = 14;            // viewport size
    localparam int OW  = 13;            // viewport offset
    localparam int DXW = MW + TW;       // depth * tan
    localparam int AXW = MW + 16;       // |x| scaled
    localparam int NXW = DXW + 1;
    localparam int BXW = NXW + VW + 3;  // x dividend
    localparam int AYW = MW + VW + 16;  // |y| * w scaled
    localparam int DYW = DXW + VW;      // depth * tan * h
    localparam int NYW = DYW + 1;
    localparam int BYW = NYW + VW + 3;  // y dividend
    localparam int QB  = 19;            // quotient bits
    localparam int SCW = 20;            // screen coordinate width

    localparam int QDEPTH = 8;
    localparam int QAW    = 3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PROJ = 1'b1;

    localparam logic [3:0] CAM_AXIS_BASE = 4'd3;
    localparam logic [3:0] CAM_WORDS     = 4'd12;

    localparam logic [2:0] CFG_VIEW_VALID = 3'd0;
    localparam logic [2:0] CFG_VIEWPORT_X = 3'd1;
    localparam logic [2:0] CFG_VIEWPORT_Y = 3'd2;
    localparam logic [2:0] CFG_VIEWPORT_W = 3'd3;
    localparam logic [2:0] CFG_VIEWPORT_H = 3'd4;
    localparam logic [2:0] CFG_TAN_HALF_X = 3'd5;

    localparam logic signed [SW-1:0] Z_LIMIT =
        SW'(64'd4 << (COORD_FRAC_BITS + AXIS_FRAC_BITS));
    localparam logic [19:0] TAN_SCALE = 20'd1000000;

    typedef struct packed {
        logic               opcode;
        logic [3:0]         view_index;
        logic signed [31:0] view_value;
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
    } t_in;

    typedef struct packed {
        logic                  projected;
        logic                  in_view;
        logic signed [SCW-1:0] screen_x;
        logic signed [SCW-1:0] screen_y;
    } t_out;

    typedef struct packed {
        logic          view_valid;
        logic [OW-1:0] viewport_x;
        logic [OW-1:0] viewport_y;
        logic [VW-1:0] viewport_width;
        logic [VW-1:0] viewport_height;
        logic [TW-1:0] tan_half_x;
    } t_cfg;

    typedef struct packed {
        logic          rej;
        logic [MW-1:0] z;
        logic [MW-1:0] xmag;
        logic          xneg;
        logic [MW-1:0] ymag;
        logic          yneg;
    } t_entry;

endpackage

// ----- rtl/wtsp_front.sv -----
module wtsp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  wtsp_pkg::t_in   i_item,
    input  wtsp_pkg::t_cfg  i_cfg,
    output logic            o_push,
    output wtsp_pkg::t_entry o_entry,
    output logic [1:0]      o_inflight
);
    import wtsp_pkg::*;

    logic signed [31:0]   r_origin [3];
    logic signed [15:0]   r_axis   [9];

    logic                 r_a_vld;
    logic                 r_a_ld;
    logic [3:0]           r_a_idx;
    logic signed [15:0]   r_a_word;
    logic signed [DW-1:0] r_a_d [3];

    logic                 r_b_vld;
    logic signed [PW-1:0] r_b_p [9];

    logic                 is_load;
    logic [3:0]           a_slot;
    logic signed [SW-1:0] s [3];

    assign is_load = i_take && (i_item.opcode == OP_LOAD);
    assign a_slot  = r_a_idx - CAM_AXIS_BASE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_a_ld  <= 1'b0;
            r_b_vld <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_origin[k] <= '0;
            end
            for (int k = 0; k < 9; k++) begin
                r_axis[k] <= '0;
            end
        end else begin
            r_a_vld <= i_take && (i_item.opcode == OP_PROJ);
            r_a_ld  <= is_load && (i_item.view_index >= CAM_AXIS_BASE)
                       && (i_item.view_index < CAM_WORDS);
            r_b_vld <= r_a_vld;
            // origin moves at transfer time, axis words after passing through the r_a registers
            if (is_load && (i_item.view_index < CAM_AXIS_BASE)) begin
                r_origin[i_item.view_index[1:0]] <= i_item.view_value;
            end
            if (r_a_ld) begin
                r_axis[a_slot] <= r_a_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_idx  <= i_item.view_index;
        r_a_word <= i_item.view_value[15:0];
        r_a_d[0] <= DW'(i_item.world_x) - DW'(r_origin[0]);
        r_a_d[1] <= DW'(i_item.world_y) - DW'(r_origin[1]);
        r_a_d[2] <= DW'(i_item.world_z) - DW'(r_origin[2]);
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                r_b_p[r*3+k] <= r_a_d[k] * r_axis[r*3+k];
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            s[r] = SW'(r_b_p[r*3]) + SW'(r_b_p[r*3+1]) + SW'(r_b_p[r*3+2]);
        end
    end

    // right coordinate is the negated left dot product
    always_comb begin
        o_entry.rej  = !i_cfg.view_valid || (i_cfg.viewport_width == '0)
                       || (i_cfg.viewport_height == '0) || (s[0] <= Z_LIMIT);
        o_entry.z    = MW'(s[0]);
        o_entry.xneg = (s[1] > 0);
        o_entry.xmag = (s[1] < 0) ? MW'(-s[1]) : MW'(s[1]);
        o_entry.yneg = (s[2] < 0);
        o_entry.ymag = (s[2] < 0) ? MW'(-s[2]) : MW'(s[2]);
    end

    assign o_push     = r_b_vld;
    assign o_inflight = {1'b0, r_a_vld} + {1'b0, r_b_vld};

endmodule

// ----- rtl/wtsp_queue.sv -----
module wtsp_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  wtsp_pkg::t_entry       i_entry,
    input  logic                   i_pop,
    output wtsp_pkg::t_entry       o_entry,
    output logic [wtsp_pkg::QAW:0] o_count
);
    import wtsp_pkg::*;

    t_entry         r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    assign o_entry = r_mem[r_rp];
    assign o_count = r_cnt;

endmodule

// ----- rtl/wtsp_back.sv -----
module wtsp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wtsp_pkg::t_cfg   i_cfg,
    input  logic             i_have,
    input  wtsp_pkg::t_entry i_entry,
    input  logic             i_out_stall,
    output logic             o_pop,
    output logic             o_valid,
    output wtsp_pkg::t_out   o_item
);
    import wtsp_pkg::*;

    logic                en;
    logic [TW+VW-1:0]    r_th;
    logic                r_tan_bad;
    logic [TW+VW+19:0]   th_micro;

    // stage 0
    logic                r0_vld, r0_rej, r0_xneg, r0_yneg;
    logic [DXW-1:0]      r0_dx;
    logic [AXW-1:0]      r0_ax;
    logic [MW+VW-1:0]    r0_axy;
    // stage 1
    logic                r1_vld, r1_rej, r1_xneg, r1_yneg, r1_cx;
    logic [DXW-1:0]      r1_dx;
    logic [DYW-1:0]      r1_dy;
    logic [NXW-1:0]      r1_nx;
    logic [AYW-1:0]      r1_ay;
    // stage 2
    logic                r2_vld, r2_rej, r2_xneg, r2_yneg, r2_cx, r2_cy;
    logic [DXW-1:0]      r2_dx;
    logic [DYW-1:0]      r2_dy;
    logic [NYW-1:0]      r2_ny;
    logic [BXW-1:0]      r2_bx;
    logic [BYW-1:0]      by;
    // divider stages
    logic                r_dv_vld  [QB+1];
    logic                r_dv_rej  [QB+1];
    logic                r_dv_xneg [QB+1];
    logic                r_dv_yneg [QB+1];
    logic                r_dv_cx   [QB+1];
    logic                r_dv_cy   [QB+1];
    logic [DXW-1:0]      r_dv_dx   [QB+1];
    logic [DYW-1:0]      r_dv_dy   [QB+1];
    logic [DXW-1:0]      r_dv_rx   [QB+1];
    logic [DYW-1:0]      r_dv_ry   [QB+1];
    logic [QB-1:0]       r_dv_lx   [QB+1];
    logic [QB-1:0]       r_dv_ly   [QB+1];
    logic [QB-1:0]       r_dv_qx   [QB+1];
    logic [QB-1:0]       r_dv_qy   [QB+1];
    logic [DXW-1:0]      st_rx [QB];
    logic [DYW-1:0]      st_ry [QB];
    logic                st_gx [QB];
    logic                st_gy [QB];

    logic                r_o_vld;
    t_out                r_o_item;
    t_out                fin;
    logic [SCW-1:0]      ux, vy;

    assign en    = !(r_o_vld && i_out_stall);
    assign o_pop = en && i_have;

    // tangent checks follow the registers
    assign th_micro = r_th * TAN_SCALE;
    always_ff @(posedge i_clk) begin
        r_th      <= i_cfg.tan_half_x * i_cfg.viewport_height;
        r_tan_bad <= th_micro <= (TW+VW+20)'({i_cfg.viewport_width, 16'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld  <= 1'b0;
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r_o_vld <= 1'b0;
            for (int k = 0; k <= QB; k++) begin
                r_dv_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r0_vld      <= o_pop;
            r1_vld      <= r0_vld;
            r2_vld      <= r1_vld;
            r_dv_vld[0] <= r2_vld;
            for (int k = 0; k < QB; k++) begin
                r_dv_vld[k+1] <= r_dv_vld[k];
            end
            r_o_vld     <= r_dv_vld[QB];
        end
    end

    assign by = {(NYW+VW)'(r2_ny) * (NYW+VW)'(i_cfg.viewport_height), 3'b0};

    always_comb begin
        logic [DXW:0] tx;
        logic [DYW:0] ty;
        for (int k = 0; k < QB; k++) begin
            tx       = {r_dv_rx[k], r_dv_lx[k][QB-1]};
            ty       = {r_dv_ry[k], r_dv_ly[k][QB-1]};
            st_gx[k] = tx >= {1'b0, r_dv_dx[k]};
            st_gy[k] = ty >= {1'b0, r_dv_dy[k]};
            st_rx[k] = st_gx[k] ? DXW'(tx - {1'b0, r_dv_dx[k]}) : DXW'(tx);
            st_ry[k] = st_gy[k] ? DYW'(ty - {1'b0, r_dv_dy[k]}) : DYW'(ty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_rej  <= i_entry.rej || r_tan_bad;
            r0_xneg <= i_entry.xneg;
            r0_yneg <= i_entry.yneg;
            r0_dx   <= i_entry.z * i_cfg.tan_half_x;
            r0_ax   <= {i_entry.xmag, 16'b0};
            r0_axy  <= i_entry.ymag * i_cfg.viewport_width;

            r1_rej  <= r0_rej;
            r1_xneg <= r0_xneg;
            r1_yneg <= r0_yneg;
            r1_dx   <= r0_dx;
            r1_dy   <= r0_dx * i_cfg.viewport_height;
            r1_cx   <= r0_dx < DXW'(r0_ax);
            r1_nx   <= r0_xneg ? NXW'(r0_dx) - NXW'(r0_ax) : NXW'(r0_dx) + NXW'(r0_ax);
            r1_ay   <= {r0_axy, 16'b0};

            r2_rej  <= r1_rej;
            r2_xneg <= r1_xneg;
            r2_yneg <= r1_yneg;
            r2_cx   <= r1_cx;
            r2_cy   <= r1_dy < DYW'(r1_ay);
            r2_dx   <= r1_dx;
            r2_dy   <= r1_dy;
            r2_ny   <= r1_yneg ? NYW'(r1_dy) - NYW'(r1_ay) : NYW'(r1_dy) + NYW'(r1_ay);
            r2_bx   <= {(NXW+VW)'(r1_nx) * (NXW+VW)'(i_cfg.viewport_width), 3'b0};

            // load the divider: upper dividend bits start below the divisor
            r_dv_rej[0]  <= r2_rej;
            r_dv_xneg[0] <= r2_xneg;
            r_dv_yneg[0] <= r2_yneg;
            r_dv_cx[0]   <= r2_cx;
            r_dv_cy[0]   <= r2_cy;
            r_dv_dx[0]   <= r2_dx;
            r_dv_dy[0]   <= r2_dy;
            r_dv_rx[0]   <= DXW'(r2_bx[BXW-1:QB]);
            r_dv_ry[0]   <= DYW'(by[BYW-1:QB]);
            r_dv_lx[0]   <= r2_bx[QB-1:0];
            r_dv_ly[0]   <= by[QB-1:0];
            r_dv_qx[0]   <= '0;
            r_dv_qy[0]   <= '0;
            for (int k = 0; k < QB; k++) begin
                r_dv_rej[k+1]  <= r_dv_rej[k];
                r_dv_xneg[k+1] <= r_dv_xneg[k];
                r_dv_yneg[k+1] <= r_dv_yneg[k];
                r_dv_cx[k+1]   <= r_dv_cx[k];
                r_dv_cy[k+1]   <= r_dv_cy[k];
                r_dv_dx[k+1]   <= r_dv_dx[k];
                r_dv_dy[k+1]   <= r_dv_dy[k];
                r_dv_rx[k+1]   <= st_rx[k];
                r_dv_ry[k+1]   <= st_ry[k];
                r_dv_lx[k+1]   <= {r_dv_lx[k][QB-2:0], 1'b0};
                r_dv_ly[k+1]   <= {r_dv_ly[k][QB-2:0], 1'b0};
                r_dv_qx[k+1]   <= {r_dv_qx[k][QB-2:0], st_gx[k]};
                r_dv_qy[k+1]   <= {r_dv_qy[k][QB-2:0], st_gy[k]};
            end

            r_o_item <= fin;
        end
    end

    // clamp to the viewport edge, then map into the window with y flipped; rejected points give all zeros
    always_comb begin
        if (r_dv_cx[QB]) begin
            ux = r_dv_xneg[QB] ? '0 : SCW'({i_cfg.viewport_width, 4'b0});
        end else begin
            ux = SCW'(r_dv_qx[QB]);
        end
        if (r_dv_cy[QB]) begin
            vy = r_dv_yneg[QB] ? '0 : SCW'({i_cfg.viewport_height, 4'b0});
        end else begin
            vy = SCW'(r_dv_qy[QB]);
        end
        if (r_dv_rej[QB]) begin
            fin = '0;
        end else begin
            fin.projected = 1'b1;
            fin.in_view   = !r_dv_cx[QB] && !r_dv_cy[QB];
            fin.screen_x  = SCW'({i_cfg.viewport_x, 4'b0}) + ux;
            fin.screen_y  = SCW'({i_cfg.viewport_height, 4'b0})
                            - SCW'({i_cfg.viewport_y, 4'b0}) - vy;
        end
    end

    assign o_valid = r_o_vld;
    assign o_item  = r_o_item;

endmodule

// ----- rtl/world_to_screen_projection_top.sv -----
// An input transfer reaches its result through 2 front stages, a queue write,
// 3 back stages, 20 divider stages and the output register.
// Throughput: one item per cycle unless the output stalls; the back end runs a
// 19-stage restoring divider that retires one quotient bit per stage for each axis.
// Reset clears the camera words, the queue and all valid bits, and loads the
// viewport registers with 640x480 and a unit tangent.
module world_to_screen_projection_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  wtsp_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output wtsp_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);
    import wtsp_pkg::*;

    t_cfg         r_cfg;
    logic         take;
    logic         q_push;
    logic         q_pop;
    t_entry       f_entry;
    t_entry       q_entry;
    logic [QAW:0] q_cnt;
    logic [1:0]   inflight;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !i_rst_n
                         || ((5'(q_cnt) + 5'(inflight)) >= 5'(QDEPTH));
    assign take        = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.view_valid      <= 1'b0;
            r_cfg.viewport_x      <= '0;
            r_cfg.viewport_y      <= '0;
            r_cfg.viewport_width  <= VW'(640);
            r_cfg.viewport_height <= VW'(480);
            r_cfg.tan_half_x      <= TW'(65536);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_VIEW_VALID: r_cfg.view_valid      <= i_cfg_data[0];
                CFG_VIEWPORT_X: r_cfg.viewport_x      <= i_cfg_data[OW-1:0];
                CFG_VIEWPORT_Y: r_cfg.viewport_y      <= i_cfg_data[OW-1:0];
                CFG_VIEWPORT_W: r_cfg.viewport_width  <= i_cfg_data[VW-1:0];
                CFG_VIEWPORT_H: r_cfg.viewport_height <= i_cfg_data[VW-1:0];
                CFG_TAN_HALF_X: r_cfg.tan_half_x      <= i_cfg_data[TW-1:0];
                default: begin
                end
            endcase
        end
    end

    wtsp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_item     (i_in_data),
        .i_cfg      (r_cfg),
        .o_push     (q_push),
        .o_entry    (f_entry),
        .o_inflight (inflight)
    );

    wtsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (f_entry),
        .i_pop   (q_pop),
        .o_entry (q_entry),
        .o_count (q_cnt)
    );

    wtsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_have      (q_cnt != '0),
        .i_entry     (q_entry),
        .i_out_stall (i_out_stall),
        .o_pop       (q_pop),
        .o_valid     (o_out_valid),
        .o_item      (o_out_data)
    );

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_cnt <= (QAW+1)'(QDEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_cnt != (QAW+1)'(QDEPTH)) || q_pop)
        else $error("push into full queue");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_cnt != '0)
        else $error("pop from empty queue");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.projected) |->
            (!o_out_data.in_view && o_out_data.screen_x == '0
             && o_out_data.screen_y == '0))
        else $error("rejected point carries a position");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import wtsp_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    world_to_screen_projection_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // camera and viewport mirror
    logic               view_ok;
    logic [OW-1:0]      vp_x, vp_y;
    logic [VW-1:0]      vp_w, vp_h;
    logic [TW-1:0]      tan_x;
    logic signed [31:0] cam_org [3];
    logic signed [15:0] cam_axis [9];

    t_out screen_q [$];
    int   n_fail = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   quiet_cycles = 0;

    function automatic logic [127:0] axis_pixel(input logic signed [63:0] c,
                                                input logic [127:0] cmul,
                                                input logic [127:0] den,
                                                input logic [127:0] size,
                                                inout bit in_fov);
        logic [63:0]  m;
        logic [127:0] a, n;
        m = (c < 0) ? -c : c;
        a = 128'(m) * cmul;
        if (den < a) begin
            in_fov = 0;
            return (c < 0) ? 128'd0 : 128'd16 * size;
        end
        n = (c < 0) ? den - a : den + a;
        return (n * 128'd8 * size) / den;
    endfunction

    function automatic logic signed [63:0] dot_axis(input logic signed [63:0] d [3],
                                                    input int row);
        logic signed [63:0] s;
        s = 0;
        for (int k = 0; k < 3; k++) s += d[k] * 64'(cam_axis[row * 3 + k]);
        return s;
    endfunction

    // apply one accepted transfer to the camera; return 1 with a result for projects
    function automatic bit project_point(input t_in it, output t_out r);
        logic signed [63:0] d [3];
        logic signed [63:0] z, xr, yr, sx, sy;
        logic [63:0]  w, h, t;
        logic [127:0] u, v, zz;
        bit in_fov;
        r = '0;
        in_fov = 1;
        w = 64'(vp_w);
        h = 64'(vp_h);
        t = 64'(tan_x);
        if (it.opcode == OP_LOAD) begin
            if (it.view_index < CAM_AXIS_BASE)
                cam_org[it.view_index] = it.view_value;
            else if (it.view_index < CAM_WORDS)
                cam_axis[it.view_index - CAM_AXIS_BASE] = it.view_value[15:0];
            return 0;
        end
        if (!view_ok || w == 0 || h == 0) return 1;
        d[0] = 64'(it.world_x) - 64'(cam_org[0]);
        d[1] = 64'(it.world_y) - 64'(cam_org[1]);
        d[2] = 64'(it.world_z) - 64'(cam_org[2]);
        z = dot_axis(d, 0);
        if (z <= (64'sd4 <<< (COORD_FRAC_BITS + AXIS_FRAC_BITS))) return 1;
        if (t * 64'd1000000 <= 64'd65536 || t * h * 64'd1000000 <= w * 64'd65536)
            return 1;
        xr = -dot_axis(d, 1);
        yr = dot_axis(d, 2);
        zz = 128'(z);
        u = axis_pixel(xr, 128'd65536, zz * 128'(t), 128'(w), in_fov);
        v = axis_pixel(yr, 128'd65536 * 128'(w), zz * 128'(t * h), 128'(h), in_fov);
        sx = 64'(vp_x) * 16 + 64'(u);
        sy = (64'(h) - 64'(vp_y)) * 16 - 64'(v);
        r.projected = 1'b1;
        r.in_view   = in_fov;
        r.screen_x  = sx[SCW-1:0];
        r.screen_y  = sy[SCW-1:0];
        return 1;
    endfunction

    function automatic t_in rand_item();
        logic [191:0] bits;
        t_in it;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = bits[$bits(t_in)-1:0];
        return it;
    endfunction

    function automatic t_in mk_load(input logic [3:0] idx, input logic [31:0] val);
        t_in it;
        it = rand_item();
        it.opcode = OP_LOAD;
        it.view_index = idx;
        it.view_value = val;
        return it;
    endfunction

    function automatic t_in mk_point(input logic [31:0] x, y, zc);
        t_in it;
        it = rand_item();
        it.opcode = OP_PROJ;
        it.world_x = x;
        it.world_y = y;
        it.world_z = zc;
        return it;
    endfunction

    task automatic send(input t_in it);
        t_out r;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data = it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (project_point(it, r)) screen_q.push_back(r);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (screen_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        drain();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_VIEW_VALID: view_ok = val[0];
            CFG_VIEWPORT_X: vp_x = val[OW-1:0];
            CFG_VIEWPORT_Y: vp_y = val[OW-1:0];
            CFG_VIEWPORT_W: vp_w = val[VW-1:0];
            CFG_VIEWPORT_H: vp_h = val[VW-1:0];
            CFG_TAN_HALF_X: tan_x = val[TW-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_identity(input logic signed [31:0] ox, oy, oz);
        send(mk_load(4'd0, ox));
        send(mk_load(4'd1, oy));
        send(mk_load(4'd2, oz));
        for (int k = 0; k < 9; k++)
            send(mk_load(CAM_AXIS_BASE + 4'(k), (k % 4 == 0) ? 32'sd16384 : 32'sd0));
    endtask

    task automatic test_directed();
        send(mk_point(32'd5000, 0, 0));             // view not yet valid
        cfg_write(CFG_VIEW_VALID, 32'd1);
        load_identity(0, 0, 0);
        send(mk_load(4'd12, 32'h7fffffff));          // out-of-range indexes: ignored
        send(mk_load(4'd15, 32'h80000000));
        send(mk_point(32'd1024, 0, 0));              // exactly at the depth limit
        send(mk_point(32'd1025, 0, 0));
        send(mk_point(32'd4096, 32'd100, 32'd200));
        send(mk_point(-32'd4096, 0, 0));             // behind the camera
        send(mk_point(32'd4096, 32'd400000, 0));     // far left
        send(mk_point(32'd4096, -32'd400000, 0));    // far right
        send(mk_point(32'd4096, 0, 32'd400000));     // far up
        send(mk_point(32'd4096, 0, -32'd400000));    // far down
        send(mk_point(32'h7fffffff, 32'h80000000, 32'h7fffffff));
        send(mk_point(32'h7fffffff, 32'h7fffffff, 32'h80000000));
    endtask

    task automatic test_config_extremes();
        cfg_write(CFG_VIEWPORT_X, 32'd8191);
        cfg_write(CFG_VIEWPORT_Y, 32'd8191);
        cfg_write(CFG_VIEWPORT_W, 32'd8192);
        cfg_write(CFG_VIEWPORT_H, 32'd8192);
        cfg_write(CFG_TAN_HALF_X, 32'hffffff);
        send(mk_point(32'd70000, 32'd5000, -32'd9000));
        send(mk_point(32'h7fffffff, 0, 0));
        cfg_write(CFG_VIEWPORT_W, 32'd1);
        cfg_write(CFG_VIEWPORT_H, 32'd1);
        cfg_write(CFG_TAN_HALF_X, 32'd1);            // smallest nonzero tangent, still above the reject bound
        send(mk_point(32'd70000, 0, 0));
        cfg_write(CFG_TAN_HALF_X, 32'd0);
        send(mk_point(32'd70000, 0, 0));
        cfg_write(CFG_TAN_HALF_X, 32'd65536);
        send(mk_point(32'd70000, 32'd30, 0));
        cfg_write(CFG_VIEWPORT_W, 32'd0);
        send(mk_point(32'd70000, 0, 0));
        cfg_write(CFG_VIEWPORT_W, 32'd640);
        cfg_write(CFG_VIEWPORT_H, 32'd0);
        send(mk_point(32'd70000, 0, 0));
        cfg_write(CFG_VIEWPORT_H, 32'd480);
        cfg_write(CFG_VIEWPORT_X, 32'd0);
        cfg_write(CFG_VIEWPORT_Y, 32'd0);
    endtask

    task automatic new_camera(output logic signed [31:0] org [3]);
        logic signed [31:0] a;
        for (int k = 0; k < 3; k++) begin
            org[k] = $urandom_range(7, 0) == 0 ? $urandom : $signed($urandom_range(2097152)) - 1048576;
            send(mk_load(4'(k), org[k]));
        end
        for (int k = 0; k < 9; k++) begin
            a = (k % 4 == 0) ? 32'sd16384 : 32'sd0;
            a += $signed($urandom_range(600)) - 300;
            if ($urandom_range(9) == 0) a = $urandom;
            send(mk_load(CAM_AXIS_BASE + 4'(k), a));
        end
    endtask

    task automatic test_random(input int n);
        logic signed [31:0] org [3];
        t_in it;
        new_camera(org);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(19))
                0: it = mk_load(4'($urandom_range(15)), $urandom);
                1: it = mk_point($urandom, $urandom, $urandom);
                2: begin
                    new_camera(org);
                    continue;
                end
                default: it = mk_point(org[0] + $signed($urandom_range(262144)) - 65536,
                                       org[1] + $signed($urandom_range(262144)) - 131072,
                                       org[2] + $signed($urandom_range(262144)) - 131072);
            endcase
            send(it);
        end
    endtask

    task automatic random_config();
        cfg_write(CFG_VIEWPORT_X, $urandom_range(8191));
        cfg_write(CFG_VIEWPORT_Y, $urandom_range(8191));
        cfg_write(CFG_VIEWPORT_W, $urandom_range(8192, 1));
        cfg_write(CFG_VIEWPORT_H, $urandom_range(8192, 1));
        cfg_write(CFG_TAN_HALF_X, $urandom_range(3) == 0 ? $urandom : $urandom_range(200000, 20000));
    endtask

    always @(negedge i_clk) i_out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (screen_q.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) $display("unexpected result %h", o_out_data);
            end else begin
                e = screen_q.pop_front();
                if (o_out_data.projected !== e.projected || o_out_data.in_view !== e.in_view
                    || o_out_data.screen_x !== e.screen_x
                    || o_out_data.screen_y !== e.screen_y) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("mismatch: expected p=%0b v=%0b x=%0d y=%0d, got p=%0b v=%0b x=%0d y=%0d",
                                 e.projected, e.in_view, e.screen_x, e.screen_y,
                                 o_out_data.projected, o_out_data.in_view,
                                 o_out_data.screen_x, o_out_data.screen_y);
                end
            end
        end
    end

    // watchdog: stop when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        view_ok = 0;
        vp_x = 0;
        vp_y = 0;
        vp_w = 640;
        vp_h = 480;
        tan_x = 65536;
        for (int k = 0; k < 3; k++) cam_org[k] = 0;
        for (int k = 0; k < 9; k++) cam_axis[k] = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_config_extremes();
        test_random(55);
        send_idle_pct = 83;
        random_config();
        test_random(55);
        send_idle_pct = 0;
        recv_stall_pct = 83;
        random_config();
        test_random(55);
        send_idle_pct = 24;
        recv_stall_pct = 24;
        cfg_write(CFG_TAN_HALF_X, 32'd65536);
        cfg_write(CFG_VIEWPORT_W, 32'd640);
        cfg_write(CFG_VIEWPORT_H, 32'd480);
        test_random(55);
        cfg_write(CFG_VIEW_VALID, 32'd0);
        test_random(20);

        drain();
        if (n_fail == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
